>>> sv/rfm_pkg.sv
`default_nettype none
package rfm_pkg;

    localparam int TIMER_WIDTH_DEF    = 16;
    localparam int OVERFLOW_WIDTH_DEF = 16;
    localparam int CAPTURE_W          = 16;
    localparam int CLK_W              = 27;
    localparam int FREQ_W             = 14;
    localparam int DIGIT_W            = 4;
    localparam int PERIOD_W           = 32;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [CLK_W-1:0]  CLOCK_HZ_RESET = 27'd11059200;
    localparam logic [FREQ_W-1:0] FREQ_MAX       = 14'd9999;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX     = 4'd9;

    // f / 10 == (f * 52429) >> 19 for every f below 43690
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_EDGE = 1'b1;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage
`default_nettype wire

>>> sv/rfm_front.sv
`default_nettype none
module rfm_front
    import rfm_pkg::*;
#(
    parameter int TIMER_WIDTH    = TIMER_WIDTH_DEF,
    parameter int OVERFLOW_WIDTH = OVERFLOW_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_push,
    input  wire logic                                i_opcode,
    input  wire logic [CAPTURE_W-1:0]                i_capture_value,
    input  wire t_q_stat                             i_q_stat,
    output logic                                     o_full,
    output logic                                     o_q_push,
    output logic [TIMER_WIDTH+OVERFLOW_WIDTH-1:0]    o_q_period
);

    localparam int PW = TIMER_WIDTH + OVERFLOW_WIDTH;
    localparam int CW = (TIMER_WIDTH < CAPTURE_W) ? TIMER_WIDTH : CAPTURE_W;

    logic [TIMER_WIDTH-1:0]    r_prev, n_prev;
    logic [OVERFLOW_WIDTH-1:0] r_ovf, n_ovf;
    logic                      r_have_prev, n_have_prev;

    logic                   accept;
    logic [TIMER_WIDTH-1:0] cap;
    logic [PW-1:0]          high;
    logic [PW-1:0]          prev_ext;

    assign accept   = i_push && !i_q_stat.full;
    assign o_full   = i_q_stat.full;
    assign cap      = TIMER_WIDTH'(i_capture_value[CW-1:0]);
    assign high     = {r_ovf, cap};
    assign prev_ext = PW'(r_prev);

    // a capture below the previous one with no overflow between reads as zero period
    assign o_q_period = (high >= prev_ext) ? (high - prev_ext) : '0;
    assign o_q_push   = accept && (i_opcode == OP_EDGE) && r_have_prev;

    always_comb begin
        n_prev      = r_prev;
        n_ovf       = r_ovf;
        n_have_prev = r_have_prev;
        if (accept) begin
            if (i_opcode == OP_TICK) begin
                if (r_ovf != '1) begin
                    n_ovf = r_ovf + 1'b1;
                end
            end else begin
                n_prev      = cap;
                n_ovf       = '0;
                n_have_prev = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_ovf       <= '0;
            r_have_prev <= 1'b0;
        end else begin
            r_prev      <= n_prev;
            r_ovf       <= n_ovf;
            r_have_prev <= n_have_prev;
        end
    end

    a_push_only_on_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> (accept && r_have_prev && i_opcode == OP_EDGE))
        else $error("period pushed without a second edge");

    a_edge_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == OP_EDGE) |=> (r_ovf == '0 && r_have_prev))
        else $error("edge did not restart the overflow count");

endmodule
`default_nettype wire

>>> sv/rfm_queue.sv
`default_nettype none
module rfm_queue
    import rfm_pkg::*;
#(
    parameter int WIDTH = TIMER_WIDTH_DEF + OVERFLOW_WIDTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output t_q_stat               o_stat,
    output logic [WIDTH-1:0]      o_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;

    logic do_push;
    logic do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_push) begin
            n_wptr = (r_wptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

>>> sv/rfm_back.sv
`default_nettype none
module rfm_back
    import rfm_pkg::*;
#(
    parameter int PW = TIMER_WIDTH_DEF + OVERFLOW_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_wr_en,
    input  wire logic [CLK_W-1:0]    i_cfg_wr_data,
    input  wire t_q_stat             i_q_stat,
    input  wire logic [PW-1:0]       i_q_period,
    output logic                     o_q_pop,
    input  wire logic                i_pop,
    output logic                     o_empty,
    output logic [FREQ_W-1:0]        o_frequency_hz,
    output logic [DIGIT_W-1:0]       o_digit_thousands,
    output logic [DIGIT_W-1:0]       o_digit_hundreds,
    output logic [DIGIT_W-1:0]       o_digit_tens,
    output logic [DIGIT_W-1:0]       o_digit_ones,
    output logic                     o_saturated,
    output logic [PERIOD_W-1:0]      o_period_ticks
);

    localparam int RW     = PW + 1;
    localparam int CNT_W  = $clog2(CLK_W);
    localparam int PROD_W = FREQ_W + DIV10_SHIFT;
    localparam int DIGS_W = 4 * DIGIT_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_CLAMP = 3'd2;
    localparam logic [2:0] S_DIG   = 3'd3;
    localparam logic [2:0] S_HOLD  = 3'd4;

    logic [2:0]          r_state;
    logic [CLK_W-1:0]    r_clock_hz;
    logic [PW-1:0]       r_div;
    logic [PW-1:0]       r_rem;
    logic [CLK_W-1:0]    r_quo;
    logic [CNT_W-1:0]    r_cnt;
    logic [1:0]          r_dcnt;
    logic [FREQ_W-1:0]   r_f;
    logic [FREQ_W-1:0]   r_freq;
    logic                r_sat;
    logic [DIGS_W-1:0]   r_digits;
    logic [PERIOD_W-1:0] r_period;

    logic                r_out_valid;
    logic [FREQ_W-1:0]   r_o_freq;
    logic [DIGS_W-1:0]   r_o_dig;
    logic                r_o_sat;
    logic [PERIOD_W-1:0] r_o_period;

    logic [63:0]         period64;
    logic [PERIOD_W-1:0] period32;
    logic [RW-1:0]       rem_sh;
    logic [RW-1:0]       div_ext;
    logic [RW-1:0]       rem_sub;
    logic                ge;
    logic                quo_big;
    logic [PROD_W-1:0]   prod;
    logic [FREQ_W-1:0]   tenq;
    logic [FREQ_W-1:0]   rest;

    assign period64 = 64'(i_q_period);
    assign period32 = (|period64[63:PERIOD_W]) ? '1 : period64[PERIOD_W-1:0];

    // restoring divide: one quotient bit a cycle, dividend shifts out of r_quo
    assign rem_sh  = {r_rem, r_quo[CLK_W-1]};
    assign div_ext = {1'b0, r_div};
    assign ge      = (rem_sh >= div_ext);
    assign rem_sub = rem_sh - div_ext;
    assign quo_big = (r_quo > CLK_W'(FREQ_MAX));

    // peel one decimal digit a cycle, ones first
    assign prod = PROD_W'(r_f) * PROD_W'(DIV10_MUL);
    assign tenq = prod[PROD_W-1:DIV10_SHIFT];
    assign rest = r_f - ((tenq << 3) + (tenq << 1));

    assign o_q_pop = (r_state == S_IDLE) && !i_q_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_clock_hz  <= CLOCK_HZ_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_clock_hz <= i_cfg_wr_data;
            end
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_stat.empty) begin
                        r_div    <= i_q_period;
                        r_rem    <= '0;
                        r_quo    <= r_clock_hz;
                        r_cnt    <= '0;
                        r_dcnt   <= '0;
                        r_period <= period32;
                        if (i_q_period == '0) begin
                            r_freq  <= FREQ_MAX;
                            r_f     <= FREQ_MAX;
                            r_sat   <= 1'b1;
                            r_state <= S_DIG;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= ge ? rem_sub[PW-1:0] : rem_sh[PW-1:0];
                    r_quo <= {r_quo[CLK_W-2:0], ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(CLK_W - 1)) begin
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    r_freq  <= quo_big ? FREQ_MAX : r_quo[FREQ_W-1:0];
                    r_f     <= quo_big ? FREQ_MAX : r_quo[FREQ_W-1:0];
                    r_sat   <= quo_big;
                    r_state <= S_DIG;
                end
                S_DIG: begin
                    r_f      <= tenq;
                    r_digits <= {rest[DIGIT_W-1:0], r_digits[DIGS_W-1:DIGIT_W]};
                    r_dcnt   <= r_dcnt + 1'b1;
                    if (r_dcnt == 2'd3) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    // wait here until the result register is free
                    if (!r_out_valid) begin
                        r_o_freq    <= r_freq;
                        r_o_dig     <= r_digits;
                        r_o_sat     <= r_sat;
                        r_o_period  <= r_period;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_empty           = !r_out_valid;
    assign o_frequency_hz    = r_o_freq;
    assign o_digit_thousands = r_o_dig[4*DIGIT_W-1:3*DIGIT_W];
    assign o_digit_hundreds  = r_o_dig[3*DIGIT_W-1:2*DIGIT_W];
    assign o_digit_tens      = r_o_dig[2*DIGIT_W-1:DIGIT_W];
    assign o_digit_ones      = r_o_dig[DIGIT_W-1:0];
    assign o_saturated       = r_o_sat;
    assign o_period_ticks    = r_o_period;

    a_sat_means_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_sat) |-> (r_o_freq == FREQ_MAX))
        else $error("saturated word without full-scale frequency");

    a_pop_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state != S_IDLE))
        else $error("period taken from queue but no work started");

    a_digits_decimal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_digit_thousands <= DIGIT_MAX && o_digit_hundreds <= DIGIT_MAX
                         && o_digit_tens <= DIGIT_MAX && o_digit_ones <= DIGIT_MAX))
        else $error("digit out of decimal range");

endmodule
`default_nettype wire

>>> sv/reciprocal_frequency_meter.sv
// Reciprocal frequency meter.
// Input queue: i_push / o_full. Each word is an event: i_opcode 0 is a timer
// overflow tick, 1 is a rising-edge capture with the timer count on
// i_capture_value. Ticks and the first edge only update the front state.
// Every later edge yields one result word: period in timer ticks, the
// frequency i_cfg clock_hz / period saturated at 9999, its four decimal
// digits, and a saturation flag (also set for a zero period).
// Result queue: o_empty / i_pop; the oldest word stays on the ports until popped.
// The clock_hz register is written with i_cfg_wr_en / i_cfg_wr_data; the user
// must write it only while idle, the block does not enforce this. A period
// passes the front, the queue, the bit-serial divider (one quotient bit per
// cycle), the clamp, the digit peeling and the output load; a zero period
// skips the divider. A new period is taken only after the last result is
// loaded; ticks go in every cycle while the two-entry period queue has room.
// When the receiver stalls the result register holds, the back end finishes
// its current period and waits, and o_full rises once the queue fills.
// Reset: clock_hz returns to 11059200, the previous capture, overflow count
// and the queues are cleared.
`default_nettype none
module reciprocal_frequency_meter
    import rfm_pkg::*;
#(
    parameter int TIMER_WIDTH    = TIMER_WIDTH_DEF,
    parameter int OVERFLOW_WIDTH = OVERFLOW_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CLK_W-1:0]     i_cfg_wr_data,
    input  wire logic                 i_push,
    output logic                      o_full,
    input  wire logic                 i_opcode,
    input  wire logic [CAPTURE_W-1:0] i_capture_value,
    output logic                      o_empty,
    input  wire logic                 i_pop,
    output logic [FREQ_W-1:0]         o_frequency_hz,
    output logic [DIGIT_W-1:0]        o_digit_thousands,
    output logic [DIGIT_W-1:0]        o_digit_hundreds,
    output logic [DIGIT_W-1:0]        o_digit_tens,
    output logic [DIGIT_W-1:0]        o_digit_ones,
    output logic                      o_saturated,
    output logic [PERIOD_W-1:0]       o_period_ticks
);

    localparam int PW = TIMER_WIDTH + OVERFLOW_WIDTH;

    t_q_stat       q_stat;
    logic          q_push;
    logic [PW-1:0] q_in_period;
    logic [PW-1:0] q_out_period;
    logic          q_pop;

    rfm_front #(
        .TIMER_WIDTH    (TIMER_WIDTH),
        .OVERFLOW_WIDTH (OVERFLOW_WIDTH)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .i_opcode        (i_opcode),
        .i_capture_value (i_capture_value),
        .i_q_stat        (q_stat),
        .o_full          (o_full),
        .o_q_push        (q_push),
        .o_q_period      (q_in_period)
    );

    rfm_queue #(
        .WIDTH (PW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in_period),
        .i_pop   (q_pop),
        .o_stat  (q_stat),
        .o_data  (q_out_period)
    );

    rfm_back #(
        .PW (PW)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_q_stat          (q_stat),
        .i_q_period        (q_out_period),
        .o_q_pop           (q_pop),
        .i_pop             (i_pop),
        .o_empty           (o_empty),
        .o_frequency_hz    (o_frequency_hz),
        .o_digit_thousands (o_digit_thousands),
        .o_digit_hundreds  (o_digit_hundreds),
        .o_digit_tens      (o_digit_tens),
        .o_digit_ones      (o_digit_ones),
        .o_saturated       (o_saturated),
        .o_period_ticks    (o_period_ticks)
    );

endmodule
`default_nettype wire

>>> verif/reciprocal_frequency_meter_test.sv
`default_nettype none
module reciprocal_frequency_meter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rfm_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int SETTLE_CYCLES = 80;
    localparam int IDLE_PERCENT = 18;

    typedef struct packed {
        logic                 opcode;
        logic [CAPTURE_W-1:0] capture;
    } t_event;

    typedef struct packed {
        logic [FREQ_W-1:0]   freq;
        logic [DIGIT_W-1:0]  thousands;
        logic [DIGIT_W-1:0]  hundreds;
        logic [DIGIT_W-1:0]  tens;
        logic [DIGIT_W-1:0]  ones;
        logic                sat;
        logic [PERIOD_W-1:0] period;
    } t_reading;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CLK_W-1:0]     i_cfg_wr_data = '0;
    logic                 i_push = 1'b0;
    logic                 i_opcode = 1'b0;
    logic [CAPTURE_W-1:0] i_capture_value = '0;
    logic                 i_pop = 1'b0;
    logic                 o_full;
    logic                 o_empty;
    logic [FREQ_W-1:0]    o_frequency_hz;
    logic [DIGIT_W-1:0]   o_digit_thousands;
    logic [DIGIT_W-1:0]   o_digit_hundreds;
    logic [DIGIT_W-1:0]   o_digit_tens;
    logic [DIGIT_W-1:0]   o_digit_ones;
    logic                 o_saturated;
    logic [PERIOD_W-1:0]  o_period_ticks;

    t_event   pending_events[$];
    t_reading expected_readings[$];

    // meter model state
    logic [CLK_W-1:0]     clock_hz_model = CLOCK_HZ_RESET;
    logic [CAPTURE_W-1:0] last_capture = '0;
    logic [15:0]          overflow_ticks = '0;
    logic                 armed = 1'b0;

    logic [CAPTURE_W-1:0] gen_capture = '0;
    logic                 no_idle = 1'b0;
    int                   error_count = 0;
    int unsigned          cycle_count = 0;

    reciprocal_frequency_meter u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_push            (i_push),
        .o_full            (o_full),
        .i_opcode          (i_opcode),
        .i_capture_value   (i_capture_value),
        .o_empty           (o_empty),
        .i_pop             (i_pop),
        .o_frequency_hz    (o_frequency_hz),
        .o_digit_thousands (o_digit_thousands),
        .o_digit_hundreds  (o_digit_hundreds),
        .o_digit_tens      (o_digit_tens),
        .o_digit_ones      (o_digit_ones),
        .o_saturated       (o_saturated),
        .o_period_ticks    (o_period_ticks)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL reciprocal_frequency_meter");
            $finish;
        end
    end

    function automatic t_reading reading_for_period(logic [63:0] period);
        t_reading    r;
        logic [63:0] quotient;
        int unsigned f;
        r.sat = 1'b0;
        if (period == 0) begin
            f = 32'(FREQ_MAX);
            r.sat = 1'b1;
        end else begin
            quotient = 64'(clock_hz_model) / period;
            if (quotient > 64'(FREQ_MAX)) begin
                f = 32'(FREQ_MAX);
                r.sat = 1'b1;
            end else begin
                f = 32'(quotient);
            end
        end
        r.freq = FREQ_W'(f);
        r.thousands = DIGIT_W'(f / 1000);
        r.hundreds = DIGIT_W'((f % 1000) / 100);
        r.tens = DIGIT_W'((f % 100) / 10);
        r.ones = DIGIT_W'(f % 10);
        r.period = (period > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : period[31:0];
        return r;
    endfunction

    task automatic apply_event(logic opcode, logic [CAPTURE_W-1:0] capture);
        logic [63:0] stamp;
        logic [63:0] period;
        if (opcode == OP_TICK) begin
            if (overflow_ticks != 16'hFFFF) overflow_ticks = overflow_ticks + 16'd1;
        end else begin
            if (armed) begin
                stamp = (64'(overflow_ticks) << 16) + 64'(capture);
                period = (stamp >= 64'(last_capture)) ? stamp - 64'(last_capture) : 64'd0;
                expected_readings.push_back(reading_for_period(period));
            end
            last_capture = capture;
            overflow_ticks = '0;
            armed = 1'b1;
        end
    endtask

    // accept a word at the rising edge and predict from the pins
    always @(posedge i_clk) begin
        if (i_rst_n && i_push && !o_full) begin
            apply_event(i_opcode, i_capture_value);
            void'(pending_events.pop_front());
        end
    end

    always @(negedge i_clk) begin
        if (pending_events.size() != 0 &&
            (no_idle || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            i_push <= 1'b1;
            i_opcode <= pending_events[0].opcode;
            i_capture_value <= pending_events[0].capture;
        end else begin
            i_push <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        i_pop <= no_idle || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    task automatic note_mismatch(string field, longint unsigned want, longint unsigned got);
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
        error_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_reading want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (expected_readings.size() == 0) begin
                $display("%0t: unexpected word, expected none actual freq %0d period %0d",
                         $time, o_frequency_hz, o_period_ticks);
                error_count++;
            end else begin
                want = expected_readings.pop_front();
                if (o_frequency_hz !== want.freq)
                    note_mismatch("frequency_hz", want.freq, o_frequency_hz);
                if (o_digit_thousands !== want.thousands)
                    note_mismatch("digit_thousands", want.thousands, o_digit_thousands);
                if (o_digit_hundreds !== want.hundreds)
                    note_mismatch("digit_hundreds", want.hundreds, o_digit_hundreds);
                if (o_digit_tens !== want.tens)
                    note_mismatch("digit_tens", want.tens, o_digit_tens);
                if (o_digit_ones !== want.ones)
                    note_mismatch("digit_ones", want.ones, o_digit_ones);
                if (o_saturated !== want.sat)
                    note_mismatch("saturated", want.sat, o_saturated);
                if (o_period_ticks !== want.period)
                    note_mismatch("period_ticks", want.period, o_period_ticks);
            end
        end
    end

    task automatic queue_event(logic opcode, logic [CAPTURE_W-1:0] capture);
        t_event ev;
        ev.opcode = opcode;
        ev.capture = capture;
        pending_events.push_back(ev);
        if (opcode == OP_EDGE) gen_capture = capture;
    endtask

    task automatic wait_idle();
        while (pending_events.size() != 0 || expected_readings.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_clock_hz(logic [CLK_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        clock_hz_model = value;
    endtask

    // mostly well-formed signal periods: overflow ticks then the edge,
    // with some noise words and mistimed ticks mixed in
    task automatic queue_random_events(int count);
        int          added;
        int unsigned mode;
        int unsigned period;
        int unsigned lo;
        int unsigned hi;
        logic [31:0] stamp;
        added = 0;
        while (added < count) begin
            mode = $urandom_range(0, 99);
            if (mode < 10) begin
                queue_event(1'($urandom_range(0, 1)), CAPTURE_W'($urandom));
                added++;
            end else begin
                if (mode < 25) begin
                    period = $urandom_range(0, 40);
                end else if (mode < 70) begin
                    lo = clock_hz_model / 12000;
                    hi = clock_hz_model / 200 + 200;
                    if (hi > 32'h3F_FFFF) hi = 32'h3F_FFFF;
                    period = $urandom_range(lo, hi);
                end else begin
                    period = $urandom_range(1, 1 << 20);
                end
                stamp = 32'(gen_capture) + period;
                if (mode >= 95) stamp = stamp + ($urandom_range(1, 3) << 16);
                repeat (stamp[31:16]) begin
                    queue_event(OP_TICK, CAPTURE_W'($urandom));
                    added++;
                end
                queue_event(OP_EDGE, stamp[15:0]);
                added++;
            end
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset clock_hz: first edge, zero, negative, saturating and
        // threshold periods
        queue_event(OP_TICK, 16'hFFFF);
        queue_event(OP_EDGE, 16'h0000);
        queue_event(OP_EDGE, 16'h0000);
        queue_event(OP_EDGE, 16'hFFFF);
        queue_event(OP_TICK, 16'h0000);
        queue_event(OP_EDGE, 16'h0000);
        queue_event(OP_EDGE, 16'h1B00);
        queue_event(OP_EDGE, 16'h1A00);
        queue_event(OP_TICK, 16'h5555);
        queue_event(OP_TICK, 16'hAAAA);
        queue_event(OP_EDGE, 16'hFFFF);
        queue_event(OP_EDGE, 16'h0001);
        queue_event(OP_EDGE, 16'd1107);
        queue_event(OP_EDGE, 16'd2212);
        queue_event(OP_EDGE, 16'd13271);
        queue_event(OP_TICK, 16'h0F0F);
        queue_event(OP_EDGE, 16'd13271);
        queue_event(OP_EDGE, 16'h8000);
        queue_event(OP_EDGE, 16'h7FFF);
        wait_idle();

        write_clock_hz(27'd100_000_000);
        queue_random_events(250);
        wait_idle();

        write_clock_hz('0);
        queue_random_events(60);
        wait_idle();

        write_clock_hz(27'h7FF_FFFF);
        queue_random_events(120);
        wait_idle();

        write_clock_hz(27'd1);
        queue_random_events(60);
        queue_event(OP_EDGE, gen_capture);
        wait_idle();

        write_clock_hz(CLOCK_HZ_RESET);
        no_idle = 1'b1;
        queue_random_events(250);
        wait_idle();
        no_idle = 1'b0;

        write_clock_hz(27'd1_000_000);
        queue_random_events(200);
        wait_idle();
        queue_random_events(200);
        wait_idle();

        if (error_count == 0)
            $display("PASS reciprocal_frequency_meter");
        else
            $display("FAIL reciprocal_frequency_meter");
        $finish;
    end

endmodule
`default_nettype wire

>>> reciprocal_frequency_meter.f
sv/rfm_pkg.sv
sv/rfm_front.sv
sv/rfm_queue.sv
sv/rfm_back.sv
sv/reciprocal_frequency_meter.sv
verif/reciprocal_frequency_meter_test.sv
